/* design/sos_pkg.sv */
// ----------------------------------------------------------------------------
// sos_pkg - shared types and constants for the set-of-stacks block
// Sizes, command and status codes, and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int PLATE_DEPTH = 4;
  localparam int MAX_PLATES  = 8;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 3;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int PIU_W   = 4;

  localparam int SLOT_W  = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;
  localparam int LVL_W   = (PLATE_DEPTH > 1) ? $clog2(PLATE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(PLATE_DEPTH + 1);
  localparam int CNT_W   = $clog2(MAX_PLATES + 1);
  localparam int CMP_W   = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
  localparam int STORE_DEPTH = MAX_PLATES * PLATE_DEPTH;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // tdata widths rounded up to whole bytes
  localparam int IN_DATA_W  = ((VAL_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STAT_W + VAL_W + PIU_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_POP_AT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch accepted item
    logic lookup;    // resolve plate position and slot, check errors
    logic push;      // write value onto plate
    logic pop;       // read top value, shrink plate, close up order
    logic load_out;  // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_done; // error or ignored command found at lookup
    logic is_push;
  } dp_stat_t;

endpackage

/* design/sos_ctrl.sv */
// ----------------------------------------------------------------------------
// sos_ctrl - sequencing controller
// Steps each command through lookup, push or pop unless lookup ends it early, and result hand-off.
// ----------------------------------------------------------------------------
module sos_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sos_pkg::dp_cmd_t  cmd,
  input  sos_pkg::dp_stat_t stat
);
  import sos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_PUSH,
    S_POP,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.lookup   = (state_r == S_LOOKUP);
    cmd.push     = (state_r == S_PUSH);
    cmd.pop      = (state_r == S_POP);
    cmd.load_out = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // new result replaces the one leaving in the same cycle
      priority if ((state_r == S_FINISH) && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                            out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_LOOKUP;
        end
        S_LOOKUP: begin
          priority if (stat.early_done) state_r <= S_FINISH;
          else if (stat.is_push)        state_r <= S_PUSH;
          else                          state_r <= S_POP;
        end
        S_PUSH: state_r <= S_FINISH;
        S_POP:  state_r <= S_FINISH;
        S_FINISH: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/sos_dp.sv */
// ----------------------------------------------------------------------------
// sos_dp - plate datapath
// Plate store memory, per-slot fill levels, list order and output register.
// ----------------------------------------------------------------------------
module sos_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sos_pkg::dp_cmd_t              cmd,
  output sos_pkg::dp_stat_t             stat,
  input  logic [sos_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [sos_pkg::VAL_W-1:0] in_push_value,
  input  logic [sos_pkg::IDX_W-1:0]     in_plate_index,
  output logic [sos_pkg::STAT_W-1:0]    out_status,
  output logic signed [sos_pkg::VAL_W-1:0] out_popped_value,
  output logic [sos_pkg::PIU_W-1:0]     out_plates_in_use
);
  import sos_pkg::*;

  // item registers
  cmd_t                     cmd_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [IDX_W-1:0]         idx_r;

  // plate state
  logic [SLOT_W-1:0] order_r   [MAX_PLATES];
  logic [SLOT_W-1:0] order_nxt [MAX_PLATES];
  logic [FILL_W-1:0] fill_r    [MAX_PLATES];
  logic [FILL_W-1:0] fill_nxt  [MAX_PLATES];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // per-item working registers
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  status_t           status_r, status_nxt;
  logic              pop_ok_r, pop_ok_nxt;

  // plate store
  logic [VAL_W-1:0]  mem [STORE_DEPTH];
  logic [VAL_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re;

  // output register
  logic [STAT_W-1:0]       out_status_r;
  logic signed [VAL_W-1:0] out_pop_r;
  logic [CNT_W-1:0]        out_cnt_r;

  // lookup decode
  logic [SLOT_W-1:0] last_pos;
  logic [SLOT_W-1:0] lk_pos;
  logic              lk_empty, lk_range;

  // push decode
  logic              need_new;
  logic [SLOT_W-1:0] tgt_slot;
  logic [FILL_W-1:0] tgt_lvl;

  // pop decode
  logic [FILL_W-1:0] pop_lvl;

  assign last_pos = SLOT_W'(count_r - CNT_W'(1));
  assign lk_pos   = (cmd_r == CMD_POP_AT) ? SLOT_W'(idx_r) : last_pos;
  assign lk_empty = (cmd_r == CMD_POP) && (count_r == '0);
  assign lk_range = (cmd_r == CMD_POP_AT) && (CMP_W'(idx_r) >= CMP_W'(count_r));

  assign stat.early_done = (cmd_r == CMD_NOP) || lk_empty || lk_range;
  assign stat.is_push    = (cmd_r == CMD_PUSH);

  assign need_new = (count_r == '0) || (fill_r[slot_r] == FILL_W'(PLATE_DEPTH));
  assign tgt_slot = need_new ? order_r[SLOT_W'(count_r)] : slot_r;
  assign tgt_lvl  = need_new ? '0 : fill_r[slot_r];
  assign pop_lvl  = fill_r[slot_r] - FILL_W'(1);

  always_comb begin
    order_nxt  = order_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = '0;

    if (cmd.load) begin
      pop_ok_nxt = 1'b0;
      status_nxt = ST_OK;
    end

    if (cmd.lookup) begin
      pos_nxt  = lk_pos;
      slot_nxt = order_r[lk_pos];
      priority if (lk_empty) status_nxt = ST_EMPTY;
      else if (lk_range)     status_nxt = ST_RANGE;
      else                   status_nxt = ST_OK;
    end

    if (cmd.push) begin
      if (need_new && (count_r == CNT_W'(MAX_PLATES))) begin
        status_nxt = ST_FULL;
      end else begin
        mem_we   = 1'b1;
        mem_addr = ADDR_W'(tgt_slot * PLATE_DEPTH) + ADDR_W'(tgt_lvl);
        fill_nxt[tgt_slot] = tgt_lvl + FILL_W'(1);
        if (need_new) count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.pop) begin
      mem_re     = 1'b1;
      mem_addr   = ADDR_W'(slot_r * PLATE_DEPTH) + ADDR_W'(pop_lvl);
      pop_ok_nxt = 1'b1;
      fill_nxt[slot_r] = pop_lvl;
      if (pop_lvl == '0) begin
        // plate emptied: later plates close up, slot parks at old list end
        for (int i = 0; i < MAX_PLATES - 1; i++) begin
          if ((CNT_W'(i) >= CNT_W'(pos_r)) && (CNT_W'(i + 1) < count_r)) begin
            order_nxt[i] = order_r[i + 1];
          end
        end
        order_nxt[last_pos] = slot_r;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PLATES; i++) begin
        order_r[i] <= SLOT_W'(i);
        fill_r[i]  <= '0;
      end
      count_r <= '0;
    end else begin
      order_r <= order_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_cmd);
      val_r <= in_push_value;
      idx_r <= in_plate_index;
    end
    slot_r   <= slot_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_pop_r    <= pop_ok_r ? signed'(rdata_r) : '0;
      out_cnt_r    <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= val_r;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  assign out_status        = out_status_r;
  assign out_popped_value  = out_pop_r;
  assign out_plates_in_use = PIU_W'(out_cnt_r);

endmodule

/* design/set_of_stacks_with_pop_at_core.sv */
// Sequence: after the input transfer the command runs lookup, push/pop and result load, then out_tvalid rises;
//   when lookup ends the command early (error status or unused command code), it goes straight to result load.
// Flow: a new command is accepted only once the previous one has loaded its result; a held result waits in the
//   output register while the next command runs, which stalls only at its own result load.
// Reset (rst_n low, synchronous): no plates in use, all fill levels zero, identity list order;
//   plate store contents are not cleared.
// ----------------------------------------------------------------------------
// set_of_stacks_with_pop_at_core - set of fixed-depth stacks with pop-at
// Push onto the last plate (opening a new one when full), pop from the last
// plate, or pop from a chosen plate; emptied plates leave the list and the
// later plates close up. One result per command: status, popped value and
// number of plates in use.
// ----------------------------------------------------------------------------
module set_of_stacks_with_pop_at_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sos_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] push_value, [34:32] plate_index
  input  logic [sos_pkg::CMD_W-1:0]         in_tuser,   // [1:0] cmd
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sos_pkg::OUT_DATA_W-1:0]    out_tdata   // [1:0] status, [33:2] popped_value,
                                                        // [37:34] plates_in_use
);
  import sos_pkg::*;

  dp_cmd_t dp_cmd;
  dp_stat_t dp_stat;

  logic signed [VAL_W-1:0] res_popped;
  logic [STAT_W-1:0]       res_status;
  logic [PIU_W-1:0]        res_plates;

  // Controller: one command in flight; ready only when idle.
  sos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (dp_cmd),
    .stat       (dp_stat)
  );

  // Datapath: plate store, fill levels, list order, output register.
  sos_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .in_cmd            (in_tuser),
    .in_push_value     (signed'(in_tdata[VAL_W-1:0])),
    .in_plate_index    (in_tdata[VAL_W+IDX_W-1:VAL_W]),
    .out_status        (res_status),
    .out_popped_value  (res_popped),
    .out_plates_in_use (res_plates)
  );

  // Pack result fields from the low bit up, zero fill to the byte boundary.
  assign out_tdata = {{(OUT_DATA_W - STAT_W - VAL_W - PIU_W){1'b0}},
                      res_plates, res_popped, res_status};

endmodule
